// File: rtl/sts_pkg.sv
// Shared types, token codes and keyword tables of the SQL token scanner.
package sts_pkg;

	localparam int OFFSET_BITS = 16;
	localparam int POS_W       = OFFSET_BITS;
	localparam int KIND_W      = 5;
	localparam int TOK_W       = 16;
	localparam int MAX_TOK     = 3;
	localparam int CNT_W       = 2;
	localparam int TOK_IDX_W   = 2;
	localparam int NUM_KW      = 10;
	localparam int FIFO_DEPTH  = 4;
	localparam int FIFO_AW     = $clog2(FIFO_DEPTH);

	localparam logic [TOK_W-1:0] LEN_MAX = '1;

	localparam logic [KIND_W-1:0] K_END     = 5'd0;
	localparam logic [KIND_W-1:0] K_ILLEGAL = 5'd1;
	localparam logic [KIND_W-1:0] K_IDENT   = 5'd2;
	localparam logic [KIND_W-1:0] K_NUMBER  = 5'd3;
	localparam logic [KIND_W-1:0] K_EQ      = 5'd4;
	localparam logic [KIND_W-1:0] K_LE      = 5'd5;
	localparam logic [KIND_W-1:0] K_NE      = 5'd6;
	localparam logic [KIND_W-1:0] K_LT      = 5'd7;
	localparam logic [KIND_W-1:0] K_GE      = 5'd8;
	localparam logic [KIND_W-1:0] K_GT      = 5'd9;
	localparam logic [KIND_W-1:0] K_SEMI    = 5'd10;
	localparam logic [KIND_W-1:0] K_LPAR    = 5'd11;
	localparam logic [KIND_W-1:0] K_RPAR    = 5'd12;
	localparam logic [KIND_W-1:0] K_COMMA   = 5'd13;
	localparam logic [KIND_W-1:0] K_STAR    = 5'd14;
	localparam logic [KIND_W-1:0] K_KW0     = 5'd15;

	localparam logic [2:0] MODE_IDLE   = 3'd0;
	localparam logic [2:0] MODE_IDENT  = 3'd1;
	localparam logic [2:0] MODE_NUMBER = 3'd2;
	localparam logic [2:0] MODE_LT     = 3'd3;
	localparam logic [2:0] MODE_GT     = 3'd4;
	localparam logic [2:0] MODE_BANG   = 3'd5;

	localparam logic [7:0] KW_TXT [NUM_KW][8] = '{
		'{"S", "E", "L", "E", "C", "T", 8'h00, 8'h00},
		'{"F", "R", "O", "M", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"W", "H", "E", "R", "E", 8'h00, 8'h00, 8'h00},
		'{"J", "O", "I", "N", 8'h00, 8'h00, 8'h00, 8'h00},
		'{"O", "N", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"G", "R", "O", "U", "P", 8'h00, 8'h00, 8'h00},
		'{"B", "Y", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00},
		'{"E", "X", "P", "L", "A", "I", "N", 8'h00},
		'{"B", "E", "T", "W", "E", "E", "N", 8'h00},
		'{"A", "N", "D", 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}
	};

	localparam logic [3:0] KW_LEN [NUM_KW] = '{
		4'd6, 4'd4, 4'd5, 4'd4, 4'd2, 4'd5, 4'd2, 4'd7, 4'd7, 4'd3
	};

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [TOK_W-1:0]  start;
		logic [TOK_W-1:0]  length;
	} tok_t;

	typedef struct packed {
		tok_t [MAX_TOK-1:0] tok;
		logic [CNT_W-1:0]   cnt;
	} bundle_t;

endpackage

// File: rtl/sts_front.sv
// Front end: takes one text byte per beat, runs the scanner state and builds token bundles.
module sts_front (
	input  logic             clk,
	input  logic             arst_n,
	input  logic [7:0]       text_byte,
	input  logic             final_byte,
	input  logic             in_valid,
	output logic             in_ready,
	input  logic             q_full,
	output logic             q_push,
	output sts_pkg::bundle_t q_data
);
	import sts_pkg::*;

	function automatic logic is_letter(input logic [7:0] c);
		return (c >= "a" && c <= "z") || (c >= "A" && c <= "Z") || c == "_" || c == ".";
	endfunction

	function automatic logic is_digit(input logic [7:0] c);
		return c >= "0" && c <= "9";
	endfunction

	function automatic logic is_space(input logic [7:0] c);
		return c == " " || c == 8'h09 || c == 8'h0A || c == 8'h0D;
	endfunction

	function automatic logic [NUM_KW-1:0] kw_match(input logic [NUM_KW-1:0] cand,
		input logic [3:0] mcnt, input logic [7:0] c);
		logic [7:0]        up;
		logic [NUM_KW-1:0] res;
		up  = (c >= "a" && c <= "z") ? c - 8'd32 : c;
		res = cand;
		for (int k = 0; k < NUM_KW; k++) begin
			if (mcnt >= KW_LEN[k] || KW_TXT[k][mcnt[2:0]] != up)
				res[k] = 1'b0;
		end
		return res;
	endfunction

	function automatic logic [KIND_W-1:0] ident_kind(input logic [NUM_KW-1:0] cand,
		input logic [3:0] mcnt);
		logic [KIND_W-1:0] kind;
		kind = K_IDENT;
		for (int k = NUM_KW - 1; k >= 0; k--) begin
			if (cand[k] && mcnt == KW_LEN[k])
				kind = KIND_W'(K_KW0 + k);
		end
		return kind;
	endfunction

	function automatic tok_t flush_tok(input logic [2:0] mode, input logic [POS_W-1:0] ps,
		input logic [TOK_W-1:0] pl, input logic [NUM_KW-1:0] cand, input logic [3:0] mcnt);
		tok_t t;
		t.start  = TOK_W'(ps);
		t.length = TOK_W'(1);
		case (mode)
			MODE_IDENT: begin
				t.kind   = ident_kind(cand, mcnt);
				t.length = pl;
			end
			MODE_NUMBER: begin
				t.kind   = K_NUMBER;
				t.length = pl;
			end
			MODE_LT:   t.kind = K_LT;
			MODE_GT:   t.kind = K_GT;
			MODE_BANG: t.kind = K_ILLEGAL;
			default:   t.kind = K_END;
		endcase
		return t;
	endfunction

	function automatic logic [KIND_W-1:0] punct_kind(input logic [7:0] c);
		case (c)
			"=":     return K_EQ;
			";":     return K_SEMI;
			"(":     return K_LPAR;
			")":     return K_RPAR;
			",":     return K_COMMA;
			"*":     return K_STAR;
			default: return K_ILLEGAL;
		endcase
	endfunction

	function automatic logic pending(input logic [2:0] mode);
		return mode == MODE_IDENT || mode == MODE_NUMBER || mode == MODE_LT ||
			mode == MODE_GT || mode == MODE_BANG;
	endfunction

	logic [2:0]        mode_q;
	logic [POS_W-1:0]  pos_q;
	logic [POS_W-1:0]  pstart_q;
	logic [NUM_KW-1:0] cand_q;
	logic [3:0]        mcnt_q;
	logic [TOK_W-1:0]  plen_q;

	logic [2:0]        mode2;
	logic [POS_W-1:0]  pstart2;
	logic [NUM_KW-1:0] cand2;
	logic [3:0]        mcnt2;
	logic [TOK_W-1:0]  plen2;

	logic              acc, letter, digit, pair_ch, used, start_new, end_now;
	logic [NUM_KW-1:0] m_cand, matched;
	logic [3:0]        m_cnt, mcnt_inc;
	logic [TOK_W-1:0]  plen_inc;
	logic [3:0]        c_vld;
	tok_t              c_tok [4];
	bundle_t           bnd;
	logic [CNT_W-1:0]  n;

	assign acc      = in_valid && in_ready;
	assign in_ready = !q_full;
	assign letter   = is_letter(text_byte);
	assign digit    = is_digit(text_byte);
	assign pair_ch  = text_byte == "<" || text_byte == ">" || text_byte == "!";
	assign plen_inc = (plen_q == LEN_MAX) ? plen_q : plen_q + TOK_W'(1);

	always_comb begin
		case (mode_q)
			MODE_IDENT:  used = letter;
			MODE_NUMBER: used = digit;
			MODE_LT:     used = text_byte == "=" || text_byte == ">";
			MODE_GT:     used = text_byte == "=";
			MODE_BANG:   used = text_byte == "=";
			default:     used = 1'b0;
		endcase
	end

	assign start_new = !used && (letter || digit || pair_ch);
	assign end_now   = !used && text_byte == 8'h00;
	assign m_cand    = start_new ? '1 : cand_q;
	assign m_cnt     = start_new ? 4'd0 : mcnt_q;
	assign matched   = kw_match(m_cand, m_cnt, text_byte);
	assign mcnt_inc  = (m_cnt == 4'hF) ? m_cnt : m_cnt + 4'd1;

	always_comb begin
		mode2   = MODE_IDLE;
		pstart2 = pstart_q;
		cand2   = cand_q;
		mcnt2   = mcnt_q;
		plen2   = plen_q;
		if (used && mode_q == MODE_IDENT) begin
			mode2 = MODE_IDENT;
			cand2 = matched;
			mcnt2 = mcnt_inc;
			plen2 = plen_inc;
		end else if (used && mode_q == MODE_NUMBER) begin
			mode2 = MODE_NUMBER;
			plen2 = plen_inc;
		end else if (start_new) begin
			pstart2 = pos_q;
			plen2   = TOK_W'(1);
			if (letter) begin
				mode2 = MODE_IDENT;
				cand2 = matched;
				mcnt2 = mcnt_inc;
			end else if (digit)
				mode2 = MODE_NUMBER;
			else if (text_byte == "<")
				mode2 = MODE_LT;
			else if (text_byte == ">")
				mode2 = MODE_GT;
			else
				mode2 = MODE_BANG;
		end
	end

	always_comb begin
		c_vld = '0;
		for (int i = 0; i < 4; i++)
			c_tok[i] = '0;

		// closing token: two-character operator or flush of the pending one
		if (used && (mode_q == MODE_LT || mode_q == MODE_GT || mode_q == MODE_BANG)) begin
			c_vld[0]        = 1'b1;
			c_tok[0].start  = TOK_W'(pstart_q);
			c_tok[0].length = TOK_W'(2);
			if (mode_q == MODE_LT)
				c_tok[0].kind = (text_byte == "=") ? K_LE : K_NE;
			else
				c_tok[0].kind = (mode_q == MODE_GT) ? K_GE : K_NE;
		end else if (!used && pending(mode_q)) begin
			c_vld[0] = 1'b1;
			c_tok[0] = flush_tok(mode_q, pstart_q, plen_q, cand_q, mcnt_q);
		end

		// token of this byte alone
		if (end_now) begin
			c_vld[1]        = 1'b1;
			c_tok[1].kind   = K_END;
			c_tok[1].start  = TOK_W'(pos_q);
			c_tok[1].length = '0;
		end else if (!used && !is_space(text_byte) && !letter && !digit && !pair_ch) begin
			c_vld[1]        = 1'b1;
			c_tok[1].kind   = punct_kind(text_byte);
			c_tok[1].start  = TOK_W'(pos_q);
			c_tok[1].length = TOK_W'(1);
		end

		// last byte: flush and end
		if (final_byte && !end_now) begin
			c_vld[2]        = pending(mode2);
			c_tok[2]        = flush_tok(mode2, pstart2, plen2, cand2, mcnt2);
			c_vld[3]        = 1'b1;
			c_tok[3].kind   = K_END;
			c_tok[3].start  = TOK_W'(pos_q + POS_W'(1));
			c_tok[3].length = '0;
		end
	end

	always_comb begin
		bnd = '0;
		n   = '0;
		for (int i = 0; i < 4; i++) begin
			if (c_vld[i]) begin
				bnd.tok[n] = c_tok[i];
				n          = n + CNT_W'(1);
			end
		end
		bnd.cnt = n;
	end

	assign q_data = bnd;
	assign q_push = acc && bnd.cnt != '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q   <= MODE_IDLE;
			pos_q    <= '0;
			pstart_q <= '0;
			cand_q   <= '1;
			mcnt_q   <= '0;
			plen_q   <= '0;
		end else if (acc) begin
			if (end_now || final_byte) begin
				mode_q   <= MODE_IDLE;
				pos_q    <= '0;
				pstart_q <= '0;
				cand_q   <= '1;
				mcnt_q   <= '0;
				plen_q   <= '0;
			end else begin
				mode_q   <= mode2;
				pos_q    <= pos_q + POS_W'(1);
				pstart_q <= pstart2;
				cand_q   <= cand2;
				mcnt_q   <= mcnt2;
				plen_q   <= plen2;
			end
		end
	end

`ifndef NO_ASSERTIONS
	a_final_resets: assert property (@(posedge clk) disable iff (!arst_n)
		acc && final_byte |=> pos_q == '0 && mode_q == MODE_IDLE)
		else $error("scanner state not cleared after last byte");
`endif

endmodule

// File: rtl/sts_fifo.sv
// Short bundle queue between the scanner front end and the token output stage.
module sts_fifo (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  sts_pkg::bundle_t push_data,
	output logic             full,
	input  logic             pop,
	output sts_pkg::bundle_t head,
	output logic             empty
);
	import sts_pkg::*;

	bundle_t            mem_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
	logic [FIFO_AW:0]   count_q;

	assign full  = count_q == (FIFO_AW + 1)'(FIFO_DEPTH);
	assign empty = count_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_data;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
			if (pop)
				rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
			if (push && !pop)
				count_q <= count_q + (FIFO_AW + 1)'(1);
			else if (pop && !push)
				count_q <= count_q - (FIFO_AW + 1)'(1);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("bundle queue overflow");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("bundle queue underflow");
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= (FIFO_AW + 1)'(FIFO_DEPTH))
		else $error("bundle queue count out of range");
`endif

endmodule

// File: rtl/sts_back.sv
// Back end: walks the tokens of the head bundle and drives the registered output beat.
module sts_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  sts_pkg::bundle_t            head,
	input  logic                        q_empty,
	output logic                        q_pop,
	output logic [sts_pkg::KIND_W-1:0]  token_kind,
	output logic [sts_pkg::TOK_W-1:0]   token_start,
	output logic [sts_pkg::TOK_W-1:0]   token_length,
	output logic                        run_last,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import sts_pkg::*;

	logic                 valid_q, last_q, load, take, is_last;
	logic [TOK_IDX_W-1:0] idx_q;
	tok_t                 tok_q;

	assign load    = !valid_q || out_ready;
	assign take    = load && !q_empty;
	assign is_last = idx_q == TOK_IDX_W'(head.cnt - CNT_W'(1));
	assign q_pop   = take && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			if (load)
				valid_q <= !q_empty;
			if (take)
				idx_q <= is_last ? '0 : idx_q + TOK_IDX_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			tok_q  <= head.tok[idx_q];
			last_q <= is_last;
		end
	end

	assign out_valid    = valid_q;
	assign token_kind   = tok_q.kind;
	assign token_start  = tok_q.start;
	assign token_length = tok_q.length;
	assign run_last     = last_q;

`ifndef NO_ASSERTIONS
	a_idx_in_bundle: assert property (@(posedge clk) disable iff (!arst_n)
		!q_empty |-> TOK_IDX_W'(idx_q) < TOK_IDX_W'(head.cnt) && head.cnt != '0)
		else $error("token index past end of bundle");
`endif

endmodule

// File: rtl/sql_token_scanner_core.sv
// Top level of the SQL token scanner: front end, bundle queue and output stage.
//
//  channel | ports                                             | dir
//  --------+---------------------------------------------------+-----
//  input   | in_valid, in_ready, text_byte, final_byte         | in
//  output  | out_valid, out_ready, token_kind, token_start,    | out
//          | token_length, run_last                            |
//
// One text byte per cycle is scanned in the front end while in_ready is high; a byte's
// tokens (1..3) go into a 4-deep bundle queue as one entry, a byte with none pushes
// nothing. The output stage sends one token beat per cycle while out_ready is high, so
// a byte's tokens hold the output one after another; the queue absorbs bursts and
// in_ready drops only when full; a token passes the queue, then the output register.
// Reset (arst_n low) clears scanner state, queue and output valid.
module sql_token_scanner_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic [7:0]                  text_byte,
	input  logic                        final_byte,
	input  logic                        in_valid,
	output logic                        in_ready,
	output logic [sts_pkg::KIND_W-1:0]  token_kind,
	output logic [sts_pkg::TOK_W-1:0]   token_start,
	output logic [sts_pkg::TOK_W-1:0]   token_length,
	output logic                        run_last,
	output logic                        out_valid,
	input  logic                        out_ready
);
	import sts_pkg::*;

	logic    q_full, q_empty, q_push, q_pop;
	bundle_t q_data, q_head;

	sts_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.text_byte  (text_byte),
		.final_byte (final_byte),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.q_full     (q_full),
		.q_push     (q_push),
		.q_data     (q_data)
	);

	sts_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_data (q_data),
		.full      (q_full),
		.pop       (q_pop),
		.head      (q_head),
		.empty     (q_empty)
	);

	sts_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (q_head),
		.q_empty      (q_empty),
		.q_pop        (q_pop),
		.token_kind   (token_kind),
		.token_start  (token_start),
		.token_length (token_length),
		.run_last     (run_last),
		.out_valid    (out_valid),
		.out_ready    (out_ready)
	);

endmodule
